// ===== rtl/core/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the small vm alu/trap executor
// opcode and trap vector codes, decoded instruction word, event codes
// ----------------------------------------------------------------------------
package svm_pkg;

	localparam int XLEN   = 16;
	localparam int RIDX_W = 3;

	// major opcodes, bits 15-12
	localparam logic [3:0] OPC_ADD  = 4'h0;
	localparam logic [3:0] OPC_AND  = 4'h1;
	localparam logic [3:0] OPC_NOT  = 4'h2;
	localparam logic [3:0] OPC_TRAP = 4'h3;

	// trap vectors, bits 7-0
	localparam logic [7:0] TRAP_RDCH = 8'h20;
	localparam logic [7:0] TRAP_OUT  = 8'h21;
	localparam logic [7:0] TRAP_PUTC = 8'h22;
	localparam logic [7:0] TRAP_IN   = 8'h24;
	localparam logic [7:0] TRAP_PUTN = 8'h25;
	localparam logic [7:0] TRAP_STOP = 8'h26;

	// condition flag codes
	localparam logic [2:0] FLAG_POS  = 3'd1;
	localparam logic [2:0] FLAG_ZERO = 3'd2;
	localparam logic [2:0] FLAG_NEG  = 3'd4;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_CHAR   = 3'd1,
		EV_NUMBER = 3'd2,
		EV_HALTED = 3'd3,
		EV_BADOP  = 3'd4
	} event_t;

	// what the back end has to do with one instruction
	typedef enum logic [3:0] {
		K_ADD     = 4'd0,
		K_AND     = 4'd1,
		K_NOT     = 4'd2,
		K_LOAD    = 4'd3,  // r0 <= console value
		K_ECHO    = 4'd4,  // r0 <= console value, char out
		K_PUTC    = 4'd5,
		K_PUTN    = 4'd6,
		K_HALT    = 4'd7,
		K_NOP     = 4'd8,
		K_BAD     = 4'd9
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [RIDX_W-1:0] dr;
		logic [RIDX_W-1:0] ra;
		logic [RIDX_W-1:0] rb;
		logic              use_imm;
		logic [XLEN-1:0]   imm;
		logic [XLEN-1:0]   in_value;
	} dec_t;

endpackage

// ===== rtl/core/small_vm_alu_trap_executor.sv =====
// ----------------------------------------------------------------------------
// small_vm_alu_trap_executor: add/and/not/trap subset executor
// front decoder and fifo feed a register-read and execute back end
// ----------------------------------------------------------------------------
// path: an accepted beat is written into the fifo, then registered into the register
//   read stage and then into the result register that drives m_tvalid
// throughput: one instruction per cycle unless m_tready holds the output; set by
//   the single execute stage and its regfile write with bypass into the read stage
// reset: clears fifo, register file valid bits (registers read as zero),
//   condition flag, halt state and the result valid bit
module small_vm_alu_trap_executor
	import svm_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // instr, in_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_value, cond_code, is_halted, zero pad
	output logic [2:0]  m_tuser    // event_res
);

	dec_t dec;
	dec_t head;
	logic full;
	logic push;
	logic pop;
	logic head_valid;

	// front end: classify the incoming beat
	svm_decode u_decode (
		.instr    (s_tdata[15:0]),
		.in_value (s_tdata[31:16]),
		.dec      (dec)
	);

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	// decoupling fifo
	svm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (dec),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back end: execute and deliver results
	svm_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	// a halt event always reports the halted state
	a_halt_flag : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == EV_HALTED)) |-> m_tdata[19])
		else $error("halt event without halted state");

	// condition code is zero or a single flag
	a_cond_onehot : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[18:16]))
		else $error("condition code not one-hot");

	// back end never pops an empty fifo
	a_pop_valid : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	// once halted, later results stay halted with no further events
	a_halt_sticky : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[19] && (m_tuser != EV_HALTED)) |-> (m_tuser == EV_NONE))
		else $error("event after halt");

endmodule

// ===== rtl/core/svm_decode.sv =====
// ----------------------------------------------------------------------------
// svm_decode: front end classifier
// splits the instruction word into operation kind, register indexes, immediate
// ----------------------------------------------------------------------------
module svm_decode
	import svm_pkg::*;
(
	input  logic [XLEN-1:0] instr,
	input  logic [XLEN-1:0] in_value,
	output dec_t            dec
);

	kind_t trap_kind;

	// trap vector classification, unknown vectors do nothing
	always_comb begin
		unique case (instr[7:0])
			TRAP_RDCH, TRAP_IN: trap_kind = K_LOAD;
			TRAP_OUT:           trap_kind = K_ECHO;
			TRAP_PUTC:          trap_kind = K_PUTC;
			TRAP_PUTN:          trap_kind = K_PUTN;
			TRAP_STOP:          trap_kind = K_HALT;
			default:            trap_kind = K_NOP;
		endcase
	end

	// opcode classification and field extraction
	always_comb begin
		dec.dr       = instr[11:9];
		dec.ra       = instr[8:6];
		dec.rb       = instr[2:0];
		dec.use_imm  = instr[5];
		dec.imm      = {{(XLEN-5){instr[4]}}, instr[4:0]};
		dec.in_value = in_value;
		unique case (instr[15:12])
			OPC_ADD:  dec.kind = K_ADD;
			OPC_AND:  dec.kind = K_AND;
			OPC_NOT:  dec.kind = K_NOT;
			OPC_TRAP: begin
				dec.kind = trap_kind;
				// trap outputs read r0 through port a
				dec.ra   = '0;
			end
			default:  dec.kind = K_BAD;
		endcase
	end

endmodule

// ===== rtl/core/svm_queue.sv =====
// ----------------------------------------------------------------------------
// svm_queue: decoupling fifo between front and back end
// holds decoded instructions, head entry shown combinationally
// ----------------------------------------------------------------------------
module svm_queue
	import svm_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dec_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output dec_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dec_t             ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/svm_exec.sv =====
// ----------------------------------------------------------------------------
// svm_exec: back end, register read stage, execute stage and result register
// owns the register file, condition flag and halt state
// ----------------------------------------------------------------------------
module svm_exec
	import svm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  dec_t            head,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,   // out_value, cond_code, is_halted, zero pad
	output logic [2:0]      m_tuser    // event_res
);

	localparam int NREGS = 2 ** RIDX_W;

	// register file, entries read as zero until first written
	logic [XLEN-1:0]  gpr_mem [NREGS];
	logic [NREGS-1:0] gpr_vld_q;

	// read stage
	logic             s1_valid_q;
	dec_t             dec_s1;
	logic [XLEN-1:0]  rda_s1;
	logic [XLEN-1:0]  rdb_s1;

	// architectural flags
	logic [2:0]       cond_q;
	logic             halted_q;

	// result register
	logic             out_valid_q;
	event_t           out_ev_q;
	logic [XLEN-1:0]  out_val_q;
	logic [2:0]       out_cond_q;
	logic             out_halt_q;

	// execute signals
	logic             adv;
	logic [XLEN-1:0]  opb;
	logic             we;
	logic [RIDX_W-1:0] wa;
	logic [XLEN-1:0]  wd;
	logic             flag_upd;
	logic             halt_set;
	event_t           ev;
	logic [XLEN-1:0]  oval;
	logic [2:0]       cond_nxt;
	logic             wr_en;

	function automatic logic [2:0] flag_of(input logic [XLEN-1:0] v);
		if (v == '0) begin
			return FLAG_ZERO;
		end
		if (v[XLEN-1]) begin
			return FLAG_NEG;
		end
		return FLAG_POS;
	endfunction

	// stage handshake
	assign adv   = s1_valid_q && (!out_valid_q || m_tready);
	assign pop   = head_valid && (!s1_valid_q || adv);
	assign wr_en = adv && we;

	// execute
	always_comb begin
		opb      = dec_s1.use_imm ? dec_s1.imm : rdb_s1;
		we       = 1'b0;
		wa       = dec_s1.dr;
		wd       = '0;
		flag_upd = 1'b0;
		halt_set = 1'b0;
		ev       = EV_NONE;
		oval     = '0;
		if (!halted_q) begin
			unique case (dec_s1.kind)
				K_ADD: begin
					we       = 1'b1;
					wd       = rda_s1 + opb;
					flag_upd = 1'b1;
				end
				K_AND: begin
					we       = 1'b1;
					wd       = rda_s1 & opb;
					flag_upd = 1'b1;
				end
				K_NOT: begin
					we       = 1'b1;
					wd       = ~rda_s1;
					flag_upd = 1'b1;
				end
				K_LOAD: begin
					we       = 1'b1;
					wa       = '0;
					wd       = dec_s1.in_value;
					flag_upd = 1'b1;
				end
				K_ECHO: begin
					we       = 1'b1;
					wa       = '0;
					wd       = dec_s1.in_value;
					flag_upd = 1'b1;
					ev       = EV_CHAR;
					oval     = {{(XLEN-8){1'b0}}, dec_s1.in_value[7:0]};
				end
				K_PUTC: begin
					ev   = EV_CHAR;
					oval = {{(XLEN-8){1'b0}}, rda_s1[7:0]};
				end
				K_PUTN: begin
					ev   = EV_NUMBER;
					oval = rda_s1;
				end
				K_HALT: begin
					halt_set = 1'b1;
					ev       = EV_HALTED;
				end
				K_BAD: begin
					ev = EV_BADOP;
				end
				default: begin
					ev = EV_NONE;
				end
			endcase
		end
		cond_nxt = flag_upd ? flag_of(wd) : cond_q;
	end

	// register file write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			gpr_mem[wa] <= wd;
		end
	end

	// register read with bypass of the write in the same cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			dec_s1 <= head;
			if (wr_en && (wa == head.ra)) begin
				rda_s1 <= wd;
			end else begin
				rda_s1 <= gpr_vld_q[head.ra] ? gpr_mem[head.ra] : '0;
			end
			if (wr_en && (wa == head.rb)) begin
				rdb_s1 <= wd;
			end else begin
				rdb_s1 <= gpr_vld_q[head.rb] ? gpr_mem[head.rb] : '0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ev_q   <= ev;
			out_val_q  <= oval;
			out_cond_q <= cond_nxt;
			out_halt_q <= halted_q || halt_set;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpr_vld_q   <= '0;
			s1_valid_q  <= 1'b0;
			cond_q      <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				gpr_vld_q[wa] <= 1'b1;
			end
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				cond_q      <= cond_nxt;
				halted_q    <= halted_q || halt_set;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ev_q;
	assign m_tdata  = {4'b0000, out_halt_q, out_cond_q, out_val_q};

endmodule

// ===== dv/tb_small_vm_alu_trap_executor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_small_vm_alu_trap_executor: self-checking bench for the alu/trap executor
// drives instruction beats with random gaps, mirrors the register file, flag
// and halt state in a behavioral executor, and compares every result beat
// in order; covers operand extremes, all trap vectors, bad opcodes,
// output back-pressure and halt last
// ----------------------------------------------------------------------------
module tb_small_vm_alu_trap_executor;
	import svm_pkg::*;

	typedef struct packed {
		event_t      ev;
		logic [15:0] out_val;
		logic [2:0]  flags;
		logic        halt;
	} exec_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // instr, in_value
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // out_value, cond_code, is_halted, zero pad
	logic [2:0]  m_tuser;   // event_res

	// behavioral copy of the machine state
	logic [15:0] vm_regs [8];
	logic [2:0]  vm_flag;
	logic        vm_halted;

	exec_result_t pending_results [$];
	int          err_cnt = 0;
	bit          src_idle = 1'b1;
	bit          snk_idle = 1'b1;
	int          hold_cycles = 0;

	small_vm_alu_trap_executor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// flag code of a written value
	function automatic logic [2:0] flag_of(logic [15:0] v);
		if (v == 16'h0000)
			return FLAG_ZERO;
		else if (v[15])
			return FLAG_NEG;
		return FLAG_POS;
	endfunction

	// execute one instruction on the mirrored state
	function automatic exec_result_t exec_predict(logic [15:0] w, logic [15:0] inval);
		exec_result_t r;
		logic [15:0]  opb;
		logic [2:0]   dr;
		logic [2:0]   sa;
		r.ev = EV_NONE;
		r.out_val = 16'h0000;
		if (!vm_halted) begin
			dr = w[11:9];
			sa = w[8:6];
			opb = w[5] ? {{11{w[4]}}, w[4:0]} : vm_regs[w[2:0]];
			case (w[15:12])
				OPC_ADD: begin
					vm_regs[dr] = vm_regs[sa] + opb;
					vm_flag = flag_of(vm_regs[dr]);
				end
				OPC_AND: begin
					vm_regs[dr] = vm_regs[sa] & opb;
					vm_flag = flag_of(vm_regs[dr]);
				end
				OPC_NOT: begin
					vm_regs[dr] = ~vm_regs[sa];
					vm_flag = flag_of(vm_regs[dr]);
				end
				OPC_TRAP: begin
					case (w[7:0])
						TRAP_RDCH, TRAP_IN: begin
							vm_regs[0] = inval;
							vm_flag = flag_of(inval);
						end
						TRAP_OUT: begin
							vm_regs[0] = inval;
							vm_flag = flag_of(inval);
							r.ev = EV_CHAR;
							r.out_val = {8'h00, inval[7:0]};
						end
						TRAP_PUTC: begin
							r.ev = EV_CHAR;
							r.out_val = {8'h00, vm_regs[0][7:0]};
						end
						TRAP_PUTN: begin
							r.ev = EV_NUMBER;
							r.out_val = vm_regs[0];
						end
						TRAP_STOP: begin
							vm_halted = 1'b1;
							r.ev = EV_HALTED;
						end
						default: ;
					endcase
				end
				default: r.ev = EV_BADOP;
			endcase
		end
		r.flags = vm_flag;
		r.halt = vm_halted;
		return r;
	endfunction

	function automatic logic [15:0] alu_word(logic [3:0] op, logic [2:0] dr, logic [2:0] sa,
		logic use_imm, logic [4:0] lo);
		return {op, dr, sa, use_imm, lo};
	endfunction

	function automatic logic [15:0] trap_word(logic [7:0] vec, logic [3:0] spare);
		return {OPC_TRAP, spare, vec};
	endfunction

	// mostly well-formed instructions, some unknown vectors and raw words, never halt
	function automatic logic [15:0] random_instr();
		int          pick;
		logic [15:0] w;
		pick = $urandom_range(0, 99);
		w = 16'($urandom);
		if (pick < 30)
			w[15:12] = OPC_ADD;
		else if (pick < 50)
			w[15:12] = OPC_AND;
		else if (pick < 60)
			w[15:12] = OPC_NOT;
		else if (pick < 85) begin
			w[15:12] = OPC_TRAP;
			case ($urandom_range(0, 4))
				0: w[7:0] = TRAP_RDCH;
				1: w[7:0] = TRAP_OUT;
				2: w[7:0] = TRAP_PUTC;
				3: w[7:0] = TRAP_IN;
				default: w[7:0] = TRAP_PUTN;
			endcase
		end else if (pick < 90)
			w[15:12] = OPC_TRAP;
		if (w[15:12] == OPC_TRAP && w[7:0] == TRAP_STOP)
			w[7:0] = ~TRAP_STOP;
		return w;
	endfunction

	function automatic logic [15:0] random_value();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// send one instruction beat and record its expected result on acceptance
	task automatic send_instr(logic [15:0] instr, logic [15:0] inval);
		int gap;
		gap = src_idle ? $urandom_range(0, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {inval, instr};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(exec_predict(instr, inval));
	endtask

	// reset state readout, operand extremes, every opcode and every trap vector but stop
	task automatic test_directed_ops();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		send_instr(trap_word(TRAP_PUTN, 4'h0), 16'h5A5A);
		send_instr(alu_word(OPC_ADD, 3'd1, 3'd0, 1'b1, 5'h0F), 16'h0000);
		send_instr(alu_word(OPC_ADD, 3'd2, 3'd1, 1'b1, 5'h10), 16'hFFFF);
		// register mode with the unused bits 4-3 set
		send_instr(alu_word(OPC_ADD, 3'd3, 3'd2, 1'b0, 5'b11001), 16'h0000);
		send_instr(alu_word(OPC_AND, 3'd4, 3'd2, 1'b1, 5'h00), 16'h1234);
		send_instr(alu_word(OPC_AND, 3'd5, 3'd2, 1'b1, 5'h1F), 16'h0000);
		send_instr(alu_word(OPC_AND, 3'd6, 3'd3, 1'b0, 5'b11101), 16'hFFFF);
		send_instr(alu_word(OPC_NOT, 3'd7, 3'd4, 1'b1, 5'h1F), 16'h0000);
		send_instr(alu_word(OPC_NOT, 3'd7, 3'd7, 1'b0, 5'h00), 16'h0000);
		send_instr(trap_word(TRAP_RDCH, 4'h0), 16'h8000);
		send_instr(trap_word(TRAP_IN, 4'h5), 16'h7FFF);
		send_instr(trap_word(TRAP_OUT, 4'hA), 16'h12AB);
		send_instr(trap_word(TRAP_OUT, 4'h0), 16'h0000);
		send_instr(trap_word(TRAP_RDCH, 4'hF), 16'hFFFF);
		send_instr(trap_word(TRAP_PUTC, 4'h3), 16'h0000);
		send_instr(trap_word(TRAP_PUTN, 4'hC), 16'h0001);
		// wrap-around on add
		send_instr(alu_word(OPC_ADD, 3'd0, 3'd0, 1'b0, 5'h00), 16'h0000);
		send_instr(alu_word(OPC_ADD, 3'd1, 3'd2, 1'b1, 5'h01), 16'h0000);
		// unknown vectors
		send_instr(trap_word(8'h23, 4'h0), 16'hFFFF);
		send_instr(trap_word(8'h00, 4'hF), 16'h1111);
		send_instr(trap_word(8'hFF, 4'h9), 16'h2222);
		// bad opcodes, one carrying the halt vector in its low byte
		send_instr(16'h4000, 16'h0000);
		send_instr(16'hFFFF, 16'hFFFF);
		send_instr(16'h7026, 16'h3333);
	endtask

	// long random stream in chunks with different idling mixes
	task automatic test_random_stream();
		int chunk;
		int n;
		for (chunk = 0; chunk < 7; chunk++) begin
			case (chunk)
				0: begin src_idle = 1'b1; snk_idle = 1'b1; end
				1: begin src_idle = 1'b0; snk_idle = 1'b0; end
				default: begin
					src_idle = 1'($urandom_range(0, 1));
					snk_idle = 1'($urandom_range(0, 1));
				end
			endcase
			for (n = 0; n < 100; n++)
				send_instr(random_instr(), random_value());
		end
	endtask

	// receiver holds off while beats keep coming, so the input stalls
	task automatic test_output_stall();
		int n;
		src_idle = 1'b0;
		snk_idle = 1'b1;
		hold_cycles = 80;
		for (n = 0; n < 24; n++)
			send_instr(random_instr(), random_value());
	endtask

	// sender pauses until the pipeline is empty, then resumes
	task automatic test_drain_pause();
		int n;
		src_idle = 1'b1;
		snk_idle = 1'b1;
		for (n = 0; n < 8; n++)
			send_instr(random_instr(), random_value());
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		for (n = 0; n < 8; n++)
			send_instr(random_instr(), random_value());
	endtask

	// halt, then beats that must be ignored
	task automatic test_halt();
		int n;
		src_idle = 1'b1;
		snk_idle = 1'b1;
		send_instr(trap_word(TRAP_STOP, 4'hA), 16'hFFFF);
		send_instr(alu_word(OPC_ADD, 3'd0, 3'd0, 1'b1, 5'h0F), 16'h0000);
		send_instr(trap_word(TRAP_RDCH, 4'h0), 16'h4321);
		send_instr(trap_word(TRAP_PUTN, 4'h0), 16'h0000);
		send_instr(16'hF000, 16'h0000);
		send_instr(trap_word(TRAP_STOP, 4'h0), 16'h0000);
		for (n = 0; n < 4; n++)
			send_instr(16'($urandom), 16'($urandom));
	endtask

	// result sink with per-beat stalls and an occasional long hold-off
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = hold_cycles + (snk_idle ? $urandom_range(0, 18) : 0);
			hold_cycles = 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		exec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat tuser %0d tdata %h", $time, m_tuser, m_tdata);
				err_cnt = err_cnt + 1;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.ev) begin
					$display("%0t: event_res expected %0d got %0d", $time, want.ev, m_tuser);
					err_cnt = err_cnt + 1;
				end
				if (m_tdata[15:0] !== want.out_val) begin
					$display("%0t: out_value expected %h got %h", $time, want.out_val,
						m_tdata[15:0]);
					err_cnt = err_cnt + 1;
				end
				if (m_tdata[18:16] !== want.flags) begin
					$display("%0t: cond_code expected %0d got %0d", $time, want.flags,
						m_tdata[18:16]);
					err_cnt = err_cnt + 1;
				end
				if (m_tdata[19] !== want.halt) begin
					$display("%0t: is_halted expected %0d got %0d", $time, want.halt,
						m_tdata[19]);
					err_cnt = err_cnt + 1;
				end
			end
		end
	end

	// watchdog
	initial begin : watchdog
		#(4_000_000);
		$display("small_vm_alu_trap_executor verification failed");
		$finish;
	end

	// reset, test sequence and final verdict
	initial begin : main_seq
		int i;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		for (i = 0; i < 8; i++)
			vm_regs[i] = 16'h0000;
		vm_flag   = 3'd0;
		vm_halted = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		test_random_stream();
		test_output_stall();
		test_drain_pause();
		test_halt();

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("small_vm_alu_trap_executor verification clean");
		else
			$display("small_vm_alu_trap_executor verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/svm_pkg.sv
rtl/core/svm_decode.sv
rtl/core/svm_queue.sv
rtl/core/svm_exec.sv
rtl/core/small_vm_alu_trap_executor.sv
dv/tb_small_vm_alu_trap_executor.sv
